@@ src/source_text_tokenizer_macros.svh @@
// assertion helpers
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define STT_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define STT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

@@ src/stt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;
	localparam int MaxTokenLenDefault  = 150;
	localparam int MaxSourceLenDefault = 65536;

	typedef enum logic [6:0] {
		M_IDLE   = 7'b0000001,
		M_ZERO   = 7'b0000010,
		M_INT    = 7'b0000100,
		M_FRAC   = 7'b0001000,
		M_EXP    = 7'b0010000,
		M_IDENT  = 7'b0100000,
		M_OPWAIT = 7'b1000000
	} mode_t;

	localparam logic [2:0] K_NUMBER = 3'd0;
	localparam logic [2:0] K_BOOL   = 3'd1;
	localparam logic [2:0] K_KEYWORD= 3'd2;
	localparam logic [2:0] K_IDENT  = 3'd3;
	localparam logic [2:0] K_OP     = 3'd4;
	localparam logic [2:0] K_SEP    = 3'd5;
	localparam logic [2:0] K_ERROR  = 3'd6;

	localparam logic [4:0] E_BAD_CHAR = 5'd0;
	localparam logic [4:0] E_BANG     = 5'd1;
	localparam logic [4:0] E_COLON    = 5'd2;
	localparam logic [4:0] E_TOO_LONG = 5'd3;

	localparam logic [1:0] B_BIN = 2'd0;
	localparam logic [1:0] B_OCT = 2'd1;
	localparam logic [1:0] B_DEC = 2'd2;
	localparam logic [1:0] B_HEX = 2'd3;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [4:0]  sub_code;
		logic [1:0]  number_base;
		logic        has_fraction;
		logic        has_exponent;
		logic [15:0] start_offset;
		logic [7:0]  token_length;
		logic        last_of_run;
	} token_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_source;
	} src_byte_t;
endpackage
`default_nettype wire

@@ src/stt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface stt_in_if;
	logic             valid;
	logic             ready;
	stt_pkg::src_byte_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface stt_out_if;
	logic             valid;
	logic             ready;
	stt_pkg::token_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/source_text_tokenizer.sv @@
`timescale 1ns / 1ps
// source_text_tokenizer: streaming lexer. one source byte is taken per cycle on
// in, and each byte yields zero, one or two token items on out (kind, sub-code,
// number attributes, start offset, length). the scanner is a single registered
// state transition per byte, so the sustained rate is one byte per cycle; a byte
// that closes one token and completes another gives two items, which go out in
// turn through a two-entry output queue, and in is held off only while that
// queue cannot take a further byte's worth of items. after an error all bytes up
// to the one marked end_of_source are dropped; end_of_source flushes any pending
// token and returns the block to its reset state.
`default_nettype none
`include "source_text_tokenizer_macros.svh"
module source_text_tokenizer #(
	parameter int MAX_TOKEN_LEN  = stt_pkg::MaxTokenLenDefault,
	parameter int MAX_SOURCE_LEN = stt_pkg::MaxSourceLenDefault
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stt_in_if.sink     in,
	stt_out_if.source  out
);
	import stt_pkg::*;

	localparam int OffW = $clog2(MAX_SOURCE_LEN);

	// scanner state
	mode_t           mode_q;
	logic [1:0]      base_q;
	logic [OffW-1:0] tstart_q;
	logic [7:0]      tcount_q;
	logic [39:0]     window_q;
	logic [7:0]      pend_q;
	logic [OffW-1:0] offset_q;
	logic            skip_q;
	logic            frac_q, exp_q;

	// output queue, two entries
	token_t     qd_q [2];
	logic [1:0] qn_q;
	logic       qh_q;

	// next-state values
	mode_t           mode_d;
	logic [1:0]      base_d;
	logic [OffW-1:0] tstart_d;
	logic [7:0]      tcount_d;
	logic [39:0]     window_d;
	logic [7:0]      pend_d;
	logic            frac_d, exp_d, skip_d;
	token_t          r0, r1;
	logic [1:0]      nres;
	logic            failed;

	logic [7:0] c;
	logic       last, acc;
	assign c    = in.data.char_code;
	assign last = in.data.end_of_source;
	assign in.ready = (qn_q == 2'd0) || (qn_q == 2'd1 && out.ready);
	assign acc  = in.valid && in.ready;

	function automatic logic is_space(input logic [7:0] x);
		return x == 8'd32 || (x >= 8'd9 && x <= 8'd13);
	endfunction
	function automatic logic is_dec(input logic [7:0] x);
		return x >= "0" && x <= "9";
	endfunction
	function automatic logic is_alpha(input logic [7:0] x);
		return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
	endfunction
	function automatic logic is_bdig(input logic [7:0] x, input logic [1:0] b);
		logic r;
		unique case (b)
			B_BIN: r = x == "0" || x == "1";
			B_OCT: r = x >= "0" && x <= "7";
			B_HEX: r = is_dec(x) || (x >= "a" && x <= "f") || (x >= "A" && x <= "F");
			default: r = is_dec(x);
		endcase
		return r;
	endfunction
	function automatic logic is_expm(input logic [7:0] x, input logic [1:0] b);
		return (b == B_HEX) ? (x == "p" || x == "P") : (x == "e" || x == "E");
	endfunction
	function automatic token_t mk(input logic [2:0] k, input logic [4:0] s,
			input logic [1:0] b, input logic f, input logic e,
			input logic [15:0] st, input logic [7:0] ln);
		token_t t;
		t.token_kind = k; t.sub_code = s; t.number_base = b;
		t.has_fraction = f; t.has_exponent = e;
		t.start_offset = st; t.token_length = ln; t.last_of_run = 1'b0;
		return t;
	endfunction

	// keyword match over the last bytes of the identifier window
	function automatic token_t id_tok(input logic [39:0] w, input logic [7:0] n,
			input logic [15:0] st);
		token_t t;
		t = mk(K_IDENT, 5'd0, 2'd0, 1'b0, 1'b0, st, n);
		if (n == 8'd5 && w == "false")             t.token_kind = K_BOOL;
		else if (n == 8'd4 && w[31:0] == "true") begin
			t.token_kind = K_BOOL; t.sub_code = 5'd1;
		end else if (n == 8'd2 && w[15:0] == "if")  t.token_kind = K_KEYWORD;
		else if (n == 8'd4 && w[31:0] == "else") begin
			t.token_kind = K_KEYWORD; t.sub_code = 5'd1;
		end else if (n == 8'd3 && w[23:0] == "var") begin
			t.token_kind = K_KEYWORD; t.sub_code = 5'd2;
		end else if (n == 8'd3 && w[23:0] == "log") begin
			t.token_kind = K_KEYWORD; t.sub_code = 5'd3;
		end else if (n == 8'd2 && w[15:0] == "fn") begin
			t.token_kind = K_KEYWORD; t.sub_code = 5'd4;
		end
		return t;
	endfunction

	logic [15:0] st16, pos16;
	assign st16  = 16'(tstart_q);
	assign pos16 = 16'(offset_q);

	// grow check: token would reach the length limit
	logic too_long;
	assign too_long = 32'(tcount_q) >= 32'(MAX_TOKEN_LEN - 1);

	token_t num_tok, cur_id;
	assign num_tok = mk(K_NUMBER, 5'd0, base_q, frac_q, exp_q, st16, tcount_q);
	assign cur_id  = id_tok(window_q, tcount_q, st16);

	// helpers for pushing results
	token_t rr [2];
	always_comb begin
		logic       handled;   // byte consumed by the pending token
		logic       start_new; // byte goes through idle handling
		token_t     first;
		logic       has_first;
		token_t     t;
		logic       emit2;
		token_t     flushed;
		logic       has_flush;
		mode_t      m2;

		mode_d = mode_q; base_d = base_q; tstart_d = tstart_q; tcount_d = tcount_q;
		window_d = window_q; pend_d = pend_q; frac_d = frac_q; exp_d = exp_q;
		skip_d = skip_q; failed = 1'b0;
		handled = 1'b0; start_new = 1'b0; has_first = 1'b0; emit2 = 1'b0;
		first = num_tok; t = num_tok; flushed = num_tok; has_flush = 1'b0;
		m2 = M_IDLE;

		if (!skip_q) begin
			// phase 1: pending token takes or rejects the byte
			unique case (mode_q)
				M_ZERO, M_INT, M_FRAC: begin
					if (mode_q == M_ZERO && (c == "b" || c == "B" || c == "o" ||
							c == "O" || c == "x" || c == "X")) begin
						handled = 1'b1;
						if (too_long) begin
							failed = 1'b1;
						end else begin
							tcount_d = tcount_q + 8'd1;
							mode_d = M_INT;
							base_d = (c == "b" || c == "B") ? B_BIN :
								(c == "o" || c == "O") ? B_OCT : B_HEX;
						end
					end else if (is_bdig(c, base_q)) begin
						handled = 1'b1;
						if (too_long) failed = 1'b1;
						else begin
							tcount_d = tcount_q + 8'd1;
							mode_d = (mode_q == M_ZERO) ? M_INT : mode_q;
						end
					end else if (mode_q != M_FRAC && c == ".") begin
						handled = 1'b1;
						if (too_long) failed = 1'b1;
						else begin
							tcount_d = tcount_q + 8'd1; frac_d = 1'b1; mode_d = M_FRAC;
						end
					end else if (is_expm(c, base_q)) begin
						handled = 1'b1;
						if (too_long) failed = 1'b1;
						else begin
							tcount_d = tcount_q + 8'd1; exp_d = 1'b1; mode_d = M_EXP;
						end
					end else begin
						has_first = 1'b1; first = num_tok; start_new = 1'b1;
					end
				end
				M_EXP: begin
					if (is_bdig(c, base_q)) begin
						handled = 1'b1;
						if (too_long) failed = 1'b1;
						else tcount_d = tcount_q + 8'd1;
					end else begin
						has_first = 1'b1; first = num_tok; start_new = 1'b1;
					end
				end
				M_IDENT: begin
					handled = 1'b1;
					if (is_space(c)) begin
						has_first = 1'b1; first = cur_id; mode_d = M_IDLE;
					end else if (too_long) failed = 1'b1;
					else begin
						tcount_d = tcount_q + 8'd1;
						window_d = {window_q[31:0], c};
					end
				end
				M_OPWAIT: begin
					has_first = 1'b1; mode_d = M_IDLE;
					first = mk(K_OP, 5'd0, 2'd0, 1'b0, 1'b0, st16, 8'd2);
					handled = 1'b1;
					priority case (pend_q)
						"~": if (c == "|") first.sub_code = 5'd9;
							else if (c == "&") first.sub_code = 5'd10;
							else begin
								first.sub_code = 5'd8; first.token_length = 8'd1;
								handled = 1'b0; start_new = 1'b1;
							end
						"<": if (c == "<") first.sub_code = 5'd15;
							else if (c == "=") first.sub_code = 5'd17;
							else begin
								first.sub_code = 5'd13; first.token_length = 8'd1;
								handled = 1'b0; start_new = 1'b1;
							end
						">": if (c == ">") first.sub_code = 5'd16;
							else if (c == "=") first.sub_code = 5'd18;
							else begin
								first.sub_code = 5'd14; first.token_length = 8'd1;
								handled = 1'b0; start_new = 1'b1;
							end
						"=": if (c == ">") first.sub_code = 5'd20;
							else begin
								first.sub_code = 5'd19; first.token_length = 8'd1;
								handled = 1'b0; start_new = 1'b1;
							end
						"!": if (c == "|") first.sub_code = 5'd11;
							else if (c == "&") first.sub_code = 5'd12;
							else begin
								first = mk(K_ERROR, E_BANG, 2'd0, 1'b0, 1'b0, st16, 8'd1);
								failed = 1'b1;
							end
						":": if (c == "=") first.sub_code = 5'd21;
							else begin
								first = mk(K_ERROR, E_COLON, 2'd0, 1'b0, 1'b0, st16, 8'd1);
								failed = 1'b1;
							end
						default: begin
							has_first = 1'b0; handled = 1'b0; start_new = 1'b1;
						end
					endcase
				end
				default: start_new = 1'b1;
			endcase
			if (failed && mode_q != M_OPWAIT) begin
				has_first = 1'b1;
				first = mk(K_ERROR, E_TOO_LONG, 2'd0, 1'b0, 1'b0, st16, tcount_q);
			end
			if (!handled && !failed) mode_d = M_IDLE;

			// phase 2: idle handling of the byte
			if (start_new && !failed) begin
				t = mk(K_OP, 5'd0, 2'd0, 1'b0, 1'b0, pos16, 8'd1);
				if (is_space(c)) begin
					mode_d = M_IDLE;
				end else if (is_dec(c) || is_alpha(c)) begin
					mode_d = is_alpha(c) ? M_IDENT : ((c == "0") ? M_ZERO : M_INT);
					tstart_d = offset_q; tcount_d = 8'd1; window_d = {32'd0, c};
					frac_d = 1'b0; exp_d = 1'b0; base_d = B_DEC;
				end else begin
					tstart_d = offset_q; mode_d = M_IDLE; emit2 = 1'b1;
					priority case (c)
						"+": t.sub_code = 5'd0;
						"*": t.sub_code = 5'd1;
						"/": t.sub_code = 5'd2;
						"-": t.sub_code = 5'd3;
						"^": t.sub_code = 5'd4;
						"%": t.sub_code = 5'd5;
						"|": t.sub_code = 5'd6;
						"&": t.sub_code = 5'd7;
						"(": begin t.token_kind = K_SEP; t.sub_code = 5'd22; end
						")": begin t.token_kind = K_SEP; t.sub_code = 5'd23; end
						"~", "!", "<", ">", "=", ":": begin
							emit2 = 1'b0; pend_d = c; mode_d = M_OPWAIT;
						end
						default: begin
							t = mk(K_ERROR, E_BAD_CHAR, 2'd0, 1'b0, 1'b0, pos16, 8'd1);
							failed = 1'b1;
						end
					endcase
				end
			end
			if (failed) begin
				mode_d = M_IDLE; skip_d = 1'b1;
			end

			// phase 3: flush at end of source
			m2 = mode_d;
			if (last && !failed) begin
				unique case (m2)
					M_ZERO, M_INT, M_FRAC, M_EXP: begin
						has_flush = 1'b1;
						flushed = mk(K_NUMBER, 5'd0, base_d, frac_d, exp_d,
							16'(tstart_d), tcount_d);
					end
					M_IDENT: begin
						has_flush = 1'b1;
						flushed = id_tok(window_d, tcount_d, 16'(tstart_d));
					end
					M_OPWAIT: begin
						has_flush = 1'b1;
						flushed = mk(K_OP, 5'd0, 2'd0, 1'b0, 1'b0, 16'(tstart_d), 8'd1);
						priority case (pend_d)
							"~": flushed.sub_code = 5'd8;
							"<": flushed.sub_code = 5'd13;
							">": flushed.sub_code = 5'd14;
							"=": flushed.sub_code = 5'd19;
							"!": begin flushed.token_kind = K_ERROR; flushed.sub_code = E_BANG; end
							default: begin flushed.token_kind = K_ERROR; flushed.sub_code = E_COLON; end
						endcase
					end
					default: has_flush = 1'b0;
				endcase
			end
		end

		// pack up to two results in order
		rr[0] = first; rr[1] = first; nres = 2'd0;
		if (has_first) begin rr[0] = first; nres = 2'd1; end
		if (emit2 || (failed && start_new)) begin
			if (nres == 2'd0) rr[0] = t; else rr[1] = t;
			nres = nres + 2'd1;
		end
		if (has_flush) begin
			if (nres == 2'd0) rr[0] = flushed; else rr[1] = flushed;
			nres = nres + 2'd1;
		end
		if (nres == 2'd1) rr[0].last_of_run = 1'b1;
		if (nres == 2'd2) rr[1].last_of_run = 1'b1;
		r0 = rr[0]; r1 = rr[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; base_q <= B_DEC; tstart_q <= '0; tcount_q <= '0;
			window_q <= '0; pend_q <= '0; offset_q <= '0; skip_q <= 1'b0;
			frac_q <= 1'b0; exp_q <= 1'b0;
		end else if (acc) begin
			if (last) begin
				mode_q <= M_IDLE; base_q <= B_DEC; tstart_q <= '0; tcount_q <= '0;
				window_q <= '0; pend_q <= '0; offset_q <= '0; skip_q <= 1'b0;
				frac_q <= 1'b0; exp_q <= 1'b0;
			end else begin
				mode_q <= mode_d; base_q <= base_d; tstart_q <= tstart_d;
				tcount_q <= tcount_d; window_q <= window_d; pend_q <= pend_d;
				// offsets wrap at the source length
				offset_q <= (offset_q == OffW'(MAX_SOURCE_LEN - 1)) ? '0 :
					offset_q + OffW'(1);
				skip_q <= skip_d;
				frac_q <= frac_d; exp_q <= exp_d;
			end
		end
	end

	// output queue: entry qh_q is the head
	logic pop;
	assign pop = out.valid && out.ready;
	assign out.valid = qn_q != 2'd0;
	assign out.data  = qd_q[qh_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q <= 2'd0; qh_q <= 1'b0;
		end else begin
			qn_q <= qn_q - {1'b0, pop} + (acc ? nres : 2'd0);
			if (pop) qh_q <= ~qh_q;
		end
	end

	always_ff @(posedge clk) begin
		logic tail;
		tail = qh_q ^ pop ^ (qn_q == 2'd1 && !pop);
		if (qn_q == 2'd0 || (qn_q == 2'd1 && pop)) tail = qh_q ^ pop;
		if (acc && nres != 2'd0) begin
			qd_q[tail] <= r0;
			if (nres == 2'd2) qd_q[~tail] <= r1;
		end
	end

	`STT_ASSERT_IMPL(a_q_bound, clk, arst_n, 1'b1, qn_q <= 2'd2)
	`STT_ASSERT_NEXT(a_last_reset, clk, arst_n, acc && last, offset_q == '0 && mode_q == M_IDLE)
	`STT_ASSERT_IMPL(a_skip_quiet, clk, arst_n, acc && skip_q, nres == 2'd0)
endmodule
`default_nettype wire

@@ tb/sv/source_text_tokenizer_test.sv @@
`timescale 1ns / 1ps
module source_text_tokenizer_test;
	import stt_pkg::*;

	localparam int TOKEN_LIMIT = MaxTokenLenDefault;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_BYTES = 2000;
	localparam int TAIL_CYCLES = 50;

	// operator and separator codes
	localparam logic [4:0] OP_ADD = 5'd0, OP_MUL = 5'd1, OP_DIV = 5'd2, OP_SUB = 5'd3;
	localparam logic [4:0] OP_POW = 5'd4, OP_MOD = 5'd5, OP_OR = 5'd6, OP_AND = 5'd7;
	localparam logic [4:0] OP_NOT = 5'd8, OP_NOR = 5'd9, OP_NAND = 5'd10;
	localparam logic [4:0] OP_BANG_OR = 5'd11, OP_BANG_AND = 5'd12;
	localparam logic [4:0] OP_LT = 5'd13, OP_GT = 5'd14, OP_SHL = 5'd15, OP_SHR = 5'd16;
	localparam logic [4:0] OP_LE = 5'd17, OP_GE = 5'd18, OP_EQ = 5'd19, OP_ARROW = 5'd20;
	localparam logic [4:0] OP_ASSIGN = 5'd21, SEP_LPAREN = 5'd22, SEP_RPAREN = 5'd23;
	// word codes
	localparam logic [4:0] BOOL_FALSE = 5'd0, BOOL_TRUE = 5'd1;
	localparam logic [4:0] KW_IF = 5'd0, KW_ELSE = 5'd1, KW_VAR = 5'd2, KW_LOG = 5'd3;
	localparam logic [4:0] KW_FN = 5'd4;
	localparam logic [4:0] NO_CODE = 5'd0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stt_in_if  src_ch ();
	stt_out_if tok_ch ();

	source_text_tokenizer uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (src_ch),
		.out   (tok_ch)
	);

	src_byte_t pending_bytes[$];
	token_t    expected_tokens[$];
	int        error_count = 0;
	int        cycle_count = 0;
	int        in_wait = 0;
	int        out_stall = 0;
	bit        calm = 1'b0;

	// scanner state mirrored for prediction
	mode_t       scan_state;
	logic [1:0]  num_base;
	logic [15:0] tok_start;
	int          tok_len;
	logic [39:0] last_chars;
	logic [7:0]  held_op;
	logic [15:0] src_pos;
	bit          dropping;
	bit          saw_point;
	bit          saw_exp;
	int          step_count;
	bit          step_failed;

	// ---------------------------------------------------------------- prediction

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_decimal(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit_of(logic [7:0] c, logic [1:0] b);
		case (b)
			B_BIN: return c == "0" || c == "1";
			B_OCT: return c >= "0" && c <= "7";
			B_HEX: return is_decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
			default: return is_decimal(c);
		endcase
	endfunction

	function automatic bit exp_marker(logic [7:0] c, logic [1:0] b);
		if (b == B_HEX)
			return c == "p" || c == "P";
		return c == "e" || c == "E";
	endfunction

	function automatic void clear_scanner();
		scan_state = M_IDLE;
		num_base = B_DEC;
		tok_start = '0;
		tok_len = 0;
		last_chars = '0;
		held_op = '0;
		src_pos = '0;
		dropping = 1'b0;
		saw_point = 1'b0;
		saw_exp = 1'b0;
	endfunction

	// at most two tokens per byte
	function automatic void push_token(logic [2:0] kind, logic [4:0] code, logic [1:0] b,
			bit frac, bit expo, logic [15:0] start, int len);
		token_t t;
		if (step_count >= 2)
			return;
		t.token_kind = kind;
		t.sub_code = code;
		t.number_base = b;
		t.has_fraction = frac;
		t.has_exponent = expo;
		t.start_offset = start;
		t.token_length = len[7:0];
		t.last_of_run = 1'b0;
		expected_tokens.push_back(t);
		step_count++;
	endfunction

	function automatic void raise_error(logic [4:0] code, logic [15:0] start, int len);
		push_token(K_ERROR, code, B_BIN, 1'b0, 1'b0, start, len);
		step_failed = 1'b1;
		dropping = 1'b1;
		scan_state = M_IDLE;
	endfunction

	function automatic bit extend_token(logic [7:0] c);
		if (tok_len >= TOKEN_LIMIT - 1) begin
			raise_error(E_TOO_LONG, tok_start, tok_len);
			return 1'b0;
		end
		tok_len++;
		last_chars = {last_chars[31:0], c};
		return 1'b1;
	endfunction

	function automatic void open_token(logic [7:0] c, mode_t m);
		scan_state = m;
		tok_start = src_pos;
		tok_len = 1;
		last_chars = {32'd0, c};
		saw_point = 1'b0;
		saw_exp = 1'b0;
		num_base = B_DEC;
	endfunction

	function automatic void close_number();
		push_token(K_NUMBER, NO_CODE, num_base, saw_point, saw_exp, tok_start, tok_len);
		scan_state = M_IDLE;
	endfunction

	// words are matched on the last bytes of the token, so only the length guards them
	function automatic void close_word();
		logic [2:0] kind;
		logic [4:0] code;
		kind = K_IDENT;
		code = NO_CODE;
		case (tok_len)
			2: begin
				if (last_chars[15:0] == "if") begin kind = K_KEYWORD; code = KW_IF; end
				else if (last_chars[15:0] == "fn") begin kind = K_KEYWORD; code = KW_FN; end
			end
			3: begin
				if (last_chars[23:0] == "var") begin kind = K_KEYWORD; code = KW_VAR; end
				else if (last_chars[23:0] == "log") begin kind = K_KEYWORD; code = KW_LOG; end
			end
			4: begin
				if (last_chars[31:0] == "true") begin kind = K_BOOL; code = BOOL_TRUE; end
				else if (last_chars[31:0] == "else") begin kind = K_KEYWORD; code = KW_ELSE; end
			end
			5: begin
				if (last_chars == "false") begin kind = K_BOOL; code = BOOL_FALSE; end
			end
			default: ;
		endcase
		push_token(kind, code, B_BIN, 1'b0, 1'b0, tok_start, tok_len);
		scan_state = M_IDLE;
	endfunction

	function automatic void push_op(logic [4:0] code, int len);
		push_token(K_OP, code, B_BIN, 1'b0, 1'b0, tok_start, len);
		scan_state = M_IDLE;
	endfunction

	function automatic void start_from_idle(logic [7:0] c);
		if (is_blank(c))
			return;
		if (is_decimal(c)) begin
			open_token(c, (c == "0") ? M_ZERO : M_INT);
			return;
		end
		if (is_letter(c)) begin
			open_token(c, M_IDENT);
			return;
		end
		tok_start = src_pos;
		case (c)
			"+": push_op(OP_ADD, 1);
			"*": push_op(OP_MUL, 1);
			"/": push_op(OP_DIV, 1);
			"-": push_op(OP_SUB, 1);
			"^": push_op(OP_POW, 1);
			"%": push_op(OP_MOD, 1);
			"|": push_op(OP_OR, 1);
			"&": push_op(OP_AND, 1);
			"(": push_token(K_SEP, SEP_LPAREN, B_BIN, 1'b0, 1'b0, src_pos, 1);
			")": push_token(K_SEP, SEP_RPAREN, B_BIN, 1'b0, 1'b0, src_pos, 1);
			"~", "!", "<", ">", "=", ":": begin
				held_op = c;
				scan_state = M_OPWAIT;
			end
			default: raise_error(E_BAD_CHAR, src_pos, 1);
		endcase
	endfunction

	// one byte of lookahead; returns whether the byte was taken
	function automatic bit settle_op(logic [7:0] c);
		case (held_op)
			"~": begin
				if (c == "|") begin push_op(OP_NOR, 2); return 1'b1; end
				if (c == "&") begin push_op(OP_NAND, 2); return 1'b1; end
				push_op(OP_NOT, 1);
				return 1'b0;
			end
			"!": begin
				if (c == "|") begin push_op(OP_BANG_OR, 2); return 1'b1; end
				if (c == "&") begin push_op(OP_BANG_AND, 2); return 1'b1; end
				raise_error(E_BANG, tok_start, 1);
				return 1'b1;
			end
			"<": begin
				if (c == "<") begin push_op(OP_SHL, 2); return 1'b1; end
				if (c == "=") begin push_op(OP_LE, 2); return 1'b1; end
				push_op(OP_LT, 1);
				return 1'b0;
			end
			">": begin
				if (c == ">") begin push_op(OP_SHR, 2); return 1'b1; end
				if (c == "=") begin push_op(OP_GE, 2); return 1'b1; end
				push_op(OP_GT, 1);
				return 1'b0;
			end
			"=": begin
				if (c == ">") begin push_op(OP_ARROW, 2); return 1'b1; end
				push_op(OP_EQ, 1);
				return 1'b0;
			end
			":": begin
				if (c == "=") begin push_op(OP_ASSIGN, 2); return 1'b1; end
				raise_error(E_COLON, tok_start, 1);
				return 1'b1;
			end
			default: begin
				scan_state = M_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void flush_token();
		case (scan_state)
			M_ZERO, M_INT, M_FRAC, M_EXP: close_number();
			M_IDENT: close_word();
			M_OPWAIT: begin
				case (held_op)
					"~": push_op(OP_NOT, 1);
					"<": push_op(OP_LT, 1);
					">": push_op(OP_GT, 1);
					"=": push_op(OP_EQ, 1);
					"!": raise_error(E_BANG, tok_start, 1);
					":": raise_error(E_COLON, tok_start, 1);
					default: ;
				endcase
			end
			default: ;
		endcase
		scan_state = M_IDLE;
	endfunction

	// works out the tokens one accepted byte gives
	function automatic void scan_byte(src_byte_t b);
		logic [7:0] c;
		bit taken;
		token_t t;
		c = b.char_code;
		taken = 1'b0;
		step_count = 0;
		step_failed = 1'b0;
		if (!dropping) begin
			// a byte that ends a token may go around again to start the next one
			for (int pass = 0; pass < 4 && !taken && !step_failed; pass++) begin
				case (scan_state)
					M_ZERO: begin
						if (c == "b" || c == "B" || c == "o" || c == "O" || c == "x" || c == "X") begin
							if (extend_token(c)) begin
								num_base = (c == "b" || c == "B") ? B_BIN :
									(c == "o" || c == "O") ? B_OCT : B_HEX;
								scan_state = M_INT;
							end
							taken = 1'b1;
						end else begin
							scan_state = M_INT;
						end
					end
					M_INT, M_FRAC: begin
						if (digit_of(c, num_base)) begin
							void'(extend_token(c));
							taken = 1'b1;
						end else if (scan_state == M_INT && c == ".") begin
							if (extend_token(c)) begin
								saw_point = 1'b1;
								scan_state = M_FRAC;
							end
							taken = 1'b1;
						end else if (exp_marker(c, num_base)) begin
							if (extend_token(c)) begin
								saw_exp = 1'b1;
								scan_state = M_EXP;
							end
							taken = 1'b1;
						end else begin
							close_number();
						end
					end
					M_EXP: begin
						if (digit_of(c, num_base)) begin
							void'(extend_token(c));
							taken = 1'b1;
						end else begin
							close_number();
						end
					end
					M_IDENT: begin
						if (is_blank(c))
							close_word();
						else
							void'(extend_token(c));
						taken = 1'b1;
					end
					M_OPWAIT: taken = settle_op(c);
					default: begin
						start_from_idle(c);
						taken = 1'b1;
					end
				endcase
			end
			if (b.end_of_source && !step_failed)
				flush_token();
		end
		// end of source returns everything to its reset state
		if (b.end_of_source)
			clear_scanner();
		else
			src_pos = src_pos + 16'd1;
		if (step_count > 0) begin
			t = expected_tokens.pop_back();
			t.last_of_run = 1'b1;
			expected_tokens.push_back(t);
		end
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic int idle_draw();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	// ---------------------------------------------------------------- stimulus

	task automatic add_text(string s);
		src_byte_t b;
		for (int i = 0; i < s.len(); i++) begin
			b.char_code = s[i];
			b.end_of_source = 1'b0;
			pending_bytes.push_back(b);
		end
	endtask

	task automatic add_char(logic [7:0] c);
		src_byte_t b;
		b.char_code = c;
		b.end_of_source = 1'b0;
		pending_bytes.push_back(b);
	endtask

	// marks the last queued byte as the end of the source
	task automatic end_source();
		src_byte_t b;
		b = pending_bytes.pop_back();
		b.end_of_source = 1'b1;
		pending_bytes.push_back(b);
	endtask

	function automatic string digits_in(logic [1:0] b, int n);
		string s;
		string pool;
		s = "";
		case (b)
			B_BIN: pool = "01";
			B_OCT: pool = "01234567";
			B_HEX: pool = "0123456789abcdefABCDEF";
			default: pool = "0123456789";
		endcase
		for (int i = 0; i < n; i++)
			s = $sformatf("%s%c", s, pool[$urandom_range(0, pool.len() - 1)]);
		return s;
	endfunction

	function automatic string random_number();
		logic [1:0] b;
		string s;
		b = 2'($urandom_range(0, 3));
		case (b)
			B_BIN: s = $urandom_range(0, 1) ? "0b" : "0B";
			B_OCT: s = $urandom_range(0, 1) ? "0o" : "0O";
			B_HEX: s = $urandom_range(0, 1) ? "0x" : "0X";
			default: s = "";
		endcase
		s = {s, digits_in(b, $urandom_range(b == B_DEC ? 1 : 0, 5))};
		if ($urandom_range(0, 2) == 0)
			s = {s, ".", digits_in(b, $urandom_range(0, 4))};
		if ($urandom_range(0, 2) == 0) begin
			if (b == B_HEX)
				s = {s, $urandom_range(0, 1) ? "p" : "P"};
			else
				s = {s, $urandom_range(0, 1) ? "e" : "E"};
			s = {s, digits_in(b, $urandom_range(0, 3))};
		end
		return s;
	endfunction

	function automatic string random_word();
		string words[7] = '{"true", "false", "if", "else", "var", "log", "fn"};
		string letters;
		string s;
		letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
		if ($urandom_range(0, 1))
			return words[$urandom_range(0, 6)];
		s = $sformatf("%c", letters[$urandom_range(0, 51)]);
		// identifiers swallow anything up to whitespace
		for (int i = $urandom_range(0, 6); i > 0; i--)
			s = $sformatf("%s%c", s, $urandom_range(0, 3) ? letters[$urandom_range(0, 51)] :
				8'($urandom_range(33, 126)));
		return s;
	endfunction

	function automatic string random_op();
		string ops[24] = '{"+", "*", "/", "-", "^", "%", "|", "&", "~", "~|", "~&", "!|",
			"!&", "<", ">", "<<", ">>", "<=", ">=", "=", "=>", ":=", "(", ")"};
		return ops[$urandom_range(0, 23)];
	endfunction

	function automatic string long_token();
		string s;
		int n;
		n = $urandom_range(TOKEN_LIMIT - 6, TOKEN_LIMIT + 4);
		s = $urandom_range(0, 1) ? "z" : "7";
		for (int i = 1; i < n; i++)
			s = {s, s[0] == "z" ? "q" : "3"};
		return s;
	endfunction

	task automatic add_random_source();
		string blanks;
		int r;
		blanks = " \t\n\v\f\r";
		for (int k = $urandom_range(1, 10); k > 0; k--) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				add_char(8'($urandom_range(0, 255)));
			else if (r < 8)
				add_text($sformatf("%c%c", $urandom_range(0, 1) ? "!" : ":",
					8'($urandom_range(32, 126))));
			else if (r < 10)
				add_text(long_token());
			else if (r < 40)
				add_text(random_number());
			else if (r < 70)
				add_text(random_word());
			else
				add_text(random_op());
			if ($urandom_range(0, 3) != 0)
				add_char(blanks[$urandom_range(0, 5)]);
		end
		end_source();
	endtask

	// ---------------------------------------------------------------- clock, reset, run

	initial begin
		forever #2 clk = ~clk;
	end

	// calm stretches with no idling on either side
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ($urandom_range(0, 199) == 0)
			calm <= ~calm;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// driver: presents queued bytes, idles between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ch.valid <= 1'b0;
			src_ch.data <= '0;
			in_wait = 0;
		end else begin
			if (src_ch.valid && src_ch.ready) begin
				scan_byte(src_ch.data);
				in_wait = idle_draw();
			end
			if (!src_ch.valid || src_ch.ready) begin
				if (in_wait > 0) begin
					in_wait--;
					src_ch.valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					src_ch.data <= pending_bytes.pop_front();
					src_ch.valid <= 1'b1;
				end else begin
					src_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every token against the oldest expectation, stalls at random
	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (tok_ch.valid && tok_ch.ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected token kind", tok_ch.data.token_kind, -1);
				end else begin
					want = expected_tokens.pop_front();
					if (tok_ch.data.token_kind !== want.token_kind)
						report_mismatch("token_kind", tok_ch.data.token_kind, want.token_kind);
					if (tok_ch.data.sub_code !== want.sub_code)
						report_mismatch("sub_code", tok_ch.data.sub_code, want.sub_code);
					if (tok_ch.data.number_base !== want.number_base)
						report_mismatch("number_base", tok_ch.data.number_base, want.number_base);
					if (tok_ch.data.has_fraction !== want.has_fraction)
						report_mismatch("has_fraction", tok_ch.data.has_fraction, want.has_fraction);
					if (tok_ch.data.has_exponent !== want.has_exponent)
						report_mismatch("has_exponent", tok_ch.data.has_exponent, want.has_exponent);
					if (tok_ch.data.start_offset !== want.start_offset)
						report_mismatch("start_offset", tok_ch.data.start_offset, want.start_offset);
					if (tok_ch.data.token_length !== want.token_length)
						report_mismatch("token_length", tok_ch.data.token_length, want.token_length);
					if (tok_ch.data.last_of_run !== want.last_of_run)
						report_mismatch("last_of_run", tok_ch.data.last_of_run, want.last_of_run);
				end
				out_stall = idle_draw();
			end
			if (out_stall > 0) begin
				out_stall--;
				tok_ch.ready <= 1'b0;
			end else begin
				tok_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int random_count;
		clear_scanner();

		// directed: number forms, words, every operator, lone lookahead operators at the end
		add_text("0x1F.8p3 0b101e1 0o17 12.5e3 0 007. true false if else var log fn abc");
		end_source();
		add_text("~|~&!|!&<<>><=>==>:=()+*/-^%|&~ < > = ");
		end_source();
		add_text("a~");
		end_source();
		add_text("1<");
		end_source();
		add_text(")>");
		end_source();
		add_text("(=");
		end_source();
		// error cases: bad bang, bad colon at the end, bad character, high byte
		add_text("!x 1 2");
		end_source();
		add_text("x :");
		end_source();
		add_text("$");
		end_source();
		add_char(8'hff);
		add_char(8'h80);
		end_source();
		add_text(long_token());
		end_source();

		random_count = 0;
		while (random_count < RANDOM_BYTES) begin
			int before_len;
			before_len = pending_bytes.size();
			add_random_source();
			random_count += pending_bytes.size() - before_len;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() > 0 || src_ch.valid)
			@(posedge clk);
		while (expected_tokens.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
